/* design/cfrp_pkg.sv */
// ----------------------------------------------------------------------------
// cfrp_pkg
// Types, codes and helpers shared by the comma field record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfrp_pkg;

    // field positions within a record
    localparam logic [2:0] FIELD_SKIP  = 3'd0;
    localparam logic [2:0] FIELD_STAMP = 3'd1;
    localparam logic [2:0] FIELD_PH_A  = 3'd2;
    localparam logic [2:0] FIELD_PH_B  = 3'd3;
    localparam logic [2:0] FIELD_PH_C  = 3'd4;
    localparam logic [2:0] FIELD_SEQ   = 3'd5;
    localparam logic [2:0] FIELD_LIMIT = 3'd6;

    // number scan phases
    localparam logic [1:0] PHASE_SKIP   = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd3;

    // sequence codes
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_ABC  = 2'd1;
    localparam logic [1:0] SEQ_ACB  = 2'd2;

    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  CHAR_COMMA = 8'h2C;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;

    // first character in the low byte
    localparam logic [23:0] TEXT_ABC = 24'h434241;
    localparam logic [23:0] TEXT_ACB = 24'h424341;

    localparam logic [2:0]  TEXT_LIMIT = 3'd4;
    localparam logic [2:0]  TEXT_MATCH_LEN = 3'd3;
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] time_stamp;
        logic signed [15:0] phase_a_value;
        logic signed [15:0] phase_b_value;
        logic signed [15:0] phase_c_value;
        logic [1:0]         sequence_code;
    } out_item_t;

    // per-field scan state
    typedef struct packed {
        logic [1:0]  scan_phase;
        logic        negative_sign;
        logic [31:0] accumulated_magnitude;
        logic [23:0] text_chars;
        logic [2:0]  text_length;
        logic        text_ended;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '0;

    function automatic logic [31:0] clamp_stamp(input logic neg, input logic [31:0] mag);
        logic [31:0] res;
        if (neg)
            res = 32'd0 - mag;
        else if (mag[31])
            res = 32'h7FFF_FFFF;
        else
            res = mag;
        return res;
    endfunction

    function automatic logic [15:0] clamp_phase(input logic neg, input logic [31:0] mag);
        logic [15:0] res;
        if (neg)
            res = (mag > 32'h0000_8000) ? 16'h8000 : (16'd0 - mag[15:0]);
        else
            res = (mag > 32'h0000_7FFF) ? 16'h7FFF : mag[15:0];
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/cfrp_scan.sv */
// ----------------------------------------------------------------------------
// cfrp_scan
// Next scan state for one non-comma byte: atoi style number scan for the
// numeric fields, short text capture for the sequence field.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrp_scan (
    input  wire logic [7:0]           data_byte,
    input  wire logic [2:0]           field_index,
    input  wire cfrp_pkg::scan_state_t cur,
    output cfrp_pkg::scan_state_t     nxt
);
    import cfrp_pkg::*;

    logic        is_space;
    logic        is_digit;
    logic        is_sign;
    logic        numeric_field;
    logic [34:0] prod;
    logic [31:0] mag_next;
    logic        take_digits;

    assign is_space = (data_byte == CHAR_SPACE) ||
                      (data_byte >= CHAR_TAB && data_byte <= CHAR_CR);
    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign is_sign  = (data_byte == CHAR_MINUS) || (data_byte == CHAR_PLUS);
    assign numeric_field = (field_index >= FIELD_STAMP) && (field_index <= FIELD_PH_C);

    // times ten as two shifts, plus the digit
    assign prod = ({3'b000, cur.accumulated_magnitude} << 3)
                + ({3'b000, cur.accumulated_magnitude} << 1)
                + {31'd0, data_byte[3:0]};
    assign mag_next = (prod > {3'b000, MAG_CAP}) ? MAG_CAP : prod[31:0];

    // a non-space, non-sign byte in skip phase is handled as a digit-phase byte
    assign take_digits = (cur.scan_phase == PHASE_DIGITS) ||
                         (cur.scan_phase == PHASE_SKIP && !is_space && !is_sign);

    always_comb
    begin
        nxt = cur;
        if (numeric_field && !cur.text_ended)
        begin
            if (data_byte == CHAR_NUL)
            begin
                nxt.text_ended = 1'b1;
            end
            else if (cur.scan_phase == PHASE_SKIP && is_sign)
            begin
                nxt.negative_sign = (data_byte == CHAR_MINUS);
                nxt.scan_phase    = PHASE_DIGITS;
            end
            else if (take_digits)
            begin
                if (is_digit)
                begin
                    nxt.scan_phase            = PHASE_DIGITS;
                    nxt.accumulated_magnitude = mag_next;
                end
                else
                begin
                    nxt.scan_phase = PHASE_DONE;
                end
            end
        end
        else if (field_index == FIELD_SEQ && !cur.text_ended)
        begin
            if (data_byte == CHAR_NUL)
            begin
                nxt.text_ended = 1'b1;
            end
            else
            begin
                case (cur.text_length)
                    3'd0:    nxt.text_chars[7:0]   = data_byte;
                    3'd1:    nxt.text_chars[15:8]  = data_byte;
                    3'd2:    nxt.text_chars[23:16] = data_byte;
                    default: nxt.text_chars        = cur.text_chars;
                endcase
                if (cur.text_length < TEXT_LIMIT)
                    nxt.text_length = cur.text_length + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/comma_field_record_parser_unit.sv */
// ----------------------------------------------------------------------------
// comma_field_record_parser_unit
// Comma separated record parser: one text byte per request, one result per
// record carrying the held timestamp, three phase values and sequence code.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : in_valid / in_ready / in_data (data_byte, last_byte).
//   out channel : out_valid / out_ready / out_data, one request per byte
//                 flagged last_byte, carrying the held values after that
//                 byte has been parsed.
//   Throughput  : one byte per cycle unless a last byte is held. The byte is
//                 captured in an input register, parsed by the number and
//                 text scan logic, and a last byte's result lands in the
//                 output register.
//   Stall       : while a result waits in the output register, ordinary
//                 bytes keep flowing; a second last byte holds in the input
//                 register (and in_ready drops) until the result is taken.
//   Reset       : rst_n clears the field index, scan state and held values
//                 to zero (sequence code none) and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module comma_field_record_parser_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cfrp_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cfrp_pkg::out_item_t       out_data
);
    import cfrp_pkg::*;

    // input register
    logic        s1_valid_reg;
    in_item_t    s1_data_reg;
    logic        s1_fire;

    // parse state
    logic [2:0]  field_index_reg,  field_index_next;
    scan_state_t scan_reg,         scan_next;
    scan_state_t scan_byte;
    logic [31:0] held_stamp_reg,   held_stamp_next;
    logic [15:0] held_a_reg,       held_a_next;
    logic [15:0] held_b_reg,       held_b_next;
    logic [15:0] held_c_reg,       held_c_next;
    logic [1:0]  held_seq_reg,     held_seq_next;

    // output register
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic        emit;

    assign s1_fire  = s1_valid_reg && (!s1_data_reg.last_byte || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign emit     = s1_fire && s1_data_reg.last_byte;

    cfrp_scan u_scan (
        .data_byte   (s1_data_reg.data_byte),
        .field_index (field_index_reg),
        .cur         (scan_reg),
        .nxt         (scan_byte)
    );

    always_comb
    begin
        field_index_next = field_index_reg;
        scan_next        = scan_reg;
        held_stamp_next  = held_stamp_reg;
        held_a_next      = held_a_reg;
        held_b_next      = held_b_reg;
        held_c_next      = held_c_reg;
        held_seq_next    = held_seq_reg;

        if (s1_data_reg.data_byte == CHAR_COMMA)
        begin
            case (field_index_reg)
                FIELD_STAMP: held_stamp_next = clamp_stamp(scan_reg.negative_sign,
                                                           scan_reg.accumulated_magnitude);
                FIELD_PH_A:  held_a_next = clamp_phase(scan_reg.negative_sign,
                                                       scan_reg.accumulated_magnitude);
                FIELD_PH_B:  held_b_next = clamp_phase(scan_reg.negative_sign,
                                                       scan_reg.accumulated_magnitude);
                FIELD_PH_C:  held_c_next = clamp_phase(scan_reg.negative_sign,
                                                       scan_reg.accumulated_magnitude);
                FIELD_SEQ:
                begin
                    if (scan_reg.text_length == TEXT_MATCH_LEN && scan_reg.text_chars == TEXT_ABC)
                        held_seq_next = SEQ_ABC;
                    else if (scan_reg.text_length == TEXT_MATCH_LEN &&
                             scan_reg.text_chars == TEXT_ACB)
                        held_seq_next = SEQ_ACB;
                end
                default: held_seq_next = held_seq_reg;
            endcase
            scan_next = SCAN_CLEAR;
            if (field_index_reg < FIELD_LIMIT)
                field_index_next = field_index_reg + 3'd1;
        end
        else
        begin
            scan_next = scan_byte;
        end

        // end of record: back to field 0, held values stay
        if (s1_data_reg.last_byte)
        begin
            field_index_next = FIELD_SKIP;
            scan_next        = SCAN_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            field_index_reg <= FIELD_SKIP;
            scan_reg        <= SCAN_CLEAR;
            held_stamp_reg  <= '0;
            held_a_reg      <= '0;
            held_b_reg      <= '0;
            held_c_reg      <= '0;
            held_seq_reg    <= SEQ_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_fire)
            begin
                field_index_reg <= field_index_next;
                scan_reg        <= scan_next;
                held_stamp_reg  <= held_stamp_next;
                held_a_reg      <= held_a_next;
                held_b_reg      <= held_b_next;
                held_c_reg      <= held_c_next;
                held_seq_reg    <= held_seq_next;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (emit)
        begin
            out_data_reg.time_stamp    <= held_stamp_next;
            out_data_reg.phase_a_value <= held_a_next;
            out_data_reg.phase_b_value <= held_b_next;
            out_data_reg.phase_c_value <= held_c_next;
            out_data_reg.sequence_code <= held_seq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // only a last byte can hold in the input register
    a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |-> s1_data_reg.last_byte)
        else $error("input register stalled on a non-last byte");

    // a new result appears only after a last byte was parsed
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("result appeared without a last byte");

    a_field_sat: assert property (@(posedge clk) disable iff (!rst_n)
        field_index_reg <= FIELD_LIMIT)
        else $error("field index beyond limit");

    a_mag_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_reg.accumulated_magnitude <= MAG_CAP) && (scan_reg.text_length <= TEXT_LIMIT))
        else $error("scan state beyond saturation");

    // record end always leaves the scanner at field 0
    a_record_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (field_index_reg == FIELD_SKIP && scan_reg == SCAN_CLEAR))
        else $error("scan state not cleared after record");

endmodule

`default_nettype wire

/* tb/comma_field_record_parser_unit_test.sv */
// ----------------------------------------------------------------------------
// comma_field_record_parser_unit_test
// Feeds text records one byte per request, with random bursts on the input
// side and a stall pattern on the output side, and checks every emitted
// record against a local parser that tracks the same field and held state.
// ----------------------------------------------------------------------------
`default_nettype none

module comma_field_record_parser_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cfrp_pkg::*;

    localparam int          RANDOM_BYTES = 760;
    localparam int          MIN_RECORDS  = 16;
    localparam int          IDLE_LIMIT   = 3000;
    localparam logic [31:0] STAMP_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] PHASE_MAX    = 32'h0000_7FFF;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    comma_field_record_parser_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // local parser state
    // ------------------------------------------------------------------
    logic [2:0]         fld_idx;
    logic [1:0]         num_phase;
    logic               num_neg;
    logic [31:0]        num_mag;
    logic [23:0]        seq_chars;
    logic [2:0]         seq_len;
    logic               fld_closed;
    logic signed [31:0] hold_stamp;
    logic signed [15:0] hold_a;
    logic signed [15:0] hold_b;
    logic signed [15:0] hold_c;
    logic [1:0]         hold_seq;

    in_item_t   tx_bytes_q[$];
    out_item_t  record_results_q[$];
    logic [7:0] rec_bytes[$];

    int fail_count = 0;
    int stim_bytes = 0;
    int stim_records = 0;
    logic req_taken = 1'b0;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // two's complement value limited to [-lim-1, lim]
    function automatic logic [31:0] saturate(input logic neg, input logic [31:0] mag,
                                             input logic [31:0] lim);
        logic [31:0] m;
        m = mag;
        if (neg)
        begin
            if (m > lim + 32'd1)
                m = lim + 32'd1;
            return 32'd0 - m;
        end
        if (m > lim)
            m = lim;
        return m;
    endfunction

    task automatic clear_scan();
        num_phase  = PHASE_SKIP;
        num_neg    = 1'b0;
        num_mag    = '0;
        seq_chars  = '0;
        seq_len    = '0;
        fld_closed = 1'b0;
    endtask

    task automatic reset_parser();
        fld_idx    = FIELD_SKIP;
        clear_scan();
        hold_stamp = '0;
        hold_a     = '0;
        hold_b     = '0;
        hold_c     = '0;
        hold_seq   = SEQ_NONE;
    endtask

    task automatic close_field();
        case (fld_idx)
            FIELD_STAMP: hold_stamp = saturate(num_neg, num_mag, STAMP_MAX);
            FIELD_PH_A:  hold_a = 16'(saturate(num_neg, num_mag, PHASE_MAX));
            FIELD_PH_B:  hold_b = 16'(saturate(num_neg, num_mag, PHASE_MAX));
            FIELD_PH_C:  hold_c = 16'(saturate(num_neg, num_mag, PHASE_MAX));
            FIELD_SEQ:
            begin
                if (seq_len == TEXT_MATCH_LEN && seq_chars == TEXT_ABC)
                    hold_seq = SEQ_ABC;
                else if (seq_len == TEXT_MATCH_LEN && seq_chars == TEXT_ACB)
                    hold_seq = SEQ_ACB;
            end
            default: ;
        endcase
        clear_scan();
        if (fld_idx < FIELD_LIMIT)
            fld_idx = fld_idx + 3'd1;
    endtask

    task automatic scan_digit(input logic [7:0] c);
        logic [35:0] wide;
        logic        consumed;
        consumed = 1'b0;
        if (num_phase == PHASE_SKIP)
        begin
            if (is_blank(c))
                consumed = 1'b1;
            else if (c == CHAR_MINUS || c == CHAR_PLUS)
            begin
                num_neg   = (c == CHAR_MINUS);
                num_phase = PHASE_DIGITS;
                consumed  = 1'b1;
            end
            else
                num_phase = PHASE_DIGITS;
        end
        if (!consumed && num_phase == PHASE_DIGITS)
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                wide = 36'(num_mag) * 36'd10 + 36'(c - CHAR_ZERO);
                num_mag = (wide > 36'(MAG_CAP)) ? MAG_CAP : wide[31:0];
            end
            else
                num_phase = PHASE_DONE;
        end
    endtask

    task automatic parse_byte(input in_item_t req);
        logic [7:0] c;
        out_item_t  res;
        c = req.data_byte;
        if (c == CHAR_COMMA)
            close_field();
        else if (fld_idx >= FIELD_STAMP && fld_idx <= FIELD_PH_C)
        begin
            if (!fld_closed)
            begin
                if (c == CHAR_NUL)
                    fld_closed = 1'b1;
                else
                    scan_digit(c);
            end
        end
        else if (fld_idx == FIELD_SEQ && !fld_closed)
        begin
            if (c == CHAR_NUL)
                fld_closed = 1'b1;
            else
            begin
                if (seq_len < TEXT_MATCH_LEN)
                    seq_chars[seq_len * 8 +: 8] = c;
                if (seq_len < TEXT_LIMIT)
                    seq_len = seq_len + 3'd1;
            end
        end
        if (req.last_byte)
        begin
            res.time_stamp    = hold_stamp;
            res.phase_a_value = hold_a;
            res.phase_b_value = hold_b;
            res.phase_c_value = hold_c;
            res.sequence_code = hold_seq;
            record_results_q.push_back(res);
            fld_idx = FIELD_SKIP;
            clear_scan();
        end
    endtask

    task automatic compare_record(input out_item_t got);
        out_item_t want;
        if (record_results_q.size() == 0)
        begin
            $error("result with no record pending: time_stamp %0d", $signed(got.time_stamp));
            fail_count++;
        end
        else
        begin
            want = record_results_q.pop_front();
            if (got.time_stamp !== want.time_stamp)
            begin
                $error("time_stamp: expected %0d, actual %0d",
                       $signed(want.time_stamp), $signed(got.time_stamp));
                fail_count++;
            end
            if (got.phase_a_value !== want.phase_a_value)
            begin
                $error("phase_a_value: expected %0d, actual %0d",
                       $signed(want.phase_a_value), $signed(got.phase_a_value));
                fail_count++;
            end
            if (got.phase_b_value !== want.phase_b_value)
            begin
                $error("phase_b_value: expected %0d, actual %0d",
                       $signed(want.phase_b_value), $signed(got.phase_b_value));
                fail_count++;
            end
            if (got.phase_c_value !== want.phase_c_value)
            begin
                $error("phase_c_value: expected %0d, actual %0d",
                       $signed(want.phase_c_value), $signed(got.phase_c_value));
                fail_count++;
            end
            if (got.sequence_code !== want.sequence_code)
            begin
                $error("sequence_code: expected %0d, actual %0d",
                       want.sequence_code, got.sequence_code);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // record building
    // ------------------------------------------------------------------
    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rec_bytes.push_back(s[i]);
    endtask

    task automatic put_byte(input logic [7:0] b);
        rec_bytes.push_back(b);
    endtask

    // last flag goes on the final byte of the record
    task automatic send_record();
        in_item_t item;
        for (int i = 0; i < rec_bytes.size(); i++)
        begin
            item.data_byte = rec_bytes[i];
            item.last_byte = (i == rec_bytes.size() - 1);
            tx_bytes_q.push_back(item);
        end
        rec_bytes.delete();
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CHAR_SPACE : 8'(CHAR_TAB + k);
    endfunction

    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_COMMA);
        return b;
    endfunction

    task automatic put_number_field();
        longint corner_vals[12];
        int     kind;
        corner_vals = '{0, 32767, 32768, -32768, -32769, 2147483647, 64'sd2147483648,
                        -64'sd2147483648, -64'sd2147483649, 64'sd99999999999,
                        -64'sd99999999999, -1};
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put_byte(pick_blank());
        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                if ($urandom_range(0, 3) == 0)
                    put_byte(CHAR_PLUS);
                put_text($sformatf("%0d", corner_vals[$urandom_range(0, 11)]));
            end
            6:  repeat ($urandom_range(8, 14)) put_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
            7:  ;
            8:  repeat ($urandom_range(1, 3)) put_byte(pick_junk());
            9:
            begin
                repeat ($urandom_range(0, 3)) put_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
                put_byte(CHAR_NUL);
                repeat ($urandom_range(0, 3)) put_byte(pick_junk());
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0, 1: put_byte(CHAR_MINUS);
                    2:    put_byte(CHAR_PLUS);
                    default: ;
                endcase
                repeat ($urandom_range(0, 6)) put_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
        endcase
        if ($urandom_range(0, 5) == 0)
            put_byte(pick_junk());
    endtask

    task automatic put_sequence_field();
        case ($urandom_range(0, 11))
            0, 1, 2, 3: put_text("ABC");
            4, 5, 6:    put_text("ACB");
            7:
            begin
                if ($urandom_range(0, 1) == 0)
                    put_text("ABCD");
                else
                    put_text("ACBX");
            end
            8:          put_text("AB");
            9:          repeat ($urandom_range(0, 4)) put_byte(pick_junk());
            10:
            begin
                if ($urandom_range(0, 1) == 0)
                    put_text("ABC");
                else
                    put_text("AC");
                put_byte(CHAR_NUL);
                put_text("B");
            end
            default:    put_text(" ACB");
        endcase
    endtask

    task automatic build_directed();
        // basic record with blanks and signs
        put_text("$R,123,-45,+67,\t 89,ABC,*00\r\n");
        send_record();
        // range extremes
        put_text("P,2147483647,32767,-32768,-0,ACB,\n");
        send_record();
        // overflow saturates, long text keeps the old code
        put_text("P,99999999999,-99999999999,32768,-32769,ABCD,\n");
        send_record();
        // empty and non-numeric fields, short text
        put_text("P,-2147483649,,x9, +,AB,\n");
        send_record();
        // nul ends a field, high bytes are not digits
        put_text("P,12");
        put_byte(CHAR_NUL);
        put_text("34,5");
        put_byte(8'hFF);
        put_text("6,");
        put_byte(8'h80);
        put_text("7,");
        put_byte(8'h0B);
        put_text("8,ABC");
        put_byte(CHAR_NUL);
        put_text("X,ACB,\n");
        send_record();
        // fields beyond the sequence are ignored, trailing text too
        put_text("M,1,2,3,4,ACB,6,7,8,9,10,11");
        send_record();
        // record cut inside a number, then a lone comma
        put_text("Q,77");
        send_record();
        put_byte(CHAR_COMMA);
        send_record();
    endtask

    task automatic build_random();
        int cut;
        while (stim_bytes < RANDOM_BYTES || stim_records < MIN_RECORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise
                repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 4)) put_byte(8'("A" + $urandom_range(0, 25)));
                for (int f = 0; f < 4; f++)
                begin
                    put_byte(CHAR_COMMA);
                    put_number_field();
                end
                put_byte(CHAR_COMMA);
                put_sequence_field();
                case ($urandom_range(0, 8))
                    6:  put_text(",1,-2,+3\n");
                    7:  ;
                    8:
                    begin
                        cut = $urandom_range(1, rec_bytes.size());
                        rec_bytes = rec_bytes[0:cut-1];
                    end
                    default: put_text($sformatf(",*%02h\r\n", $urandom_range(0, 255)));
                endcase
            end
            stim_bytes += rec_bytes.size();
            stim_records++;
            send_record();
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts with random gaps
    // ------------------------------------------------------------------
    int gap_left = 0;
    int burst_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (tx_bytes_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= tx_bytes_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern
    // ------------------------------------------------------------------
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(4, 30);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
                compare_record(out_data);
            if (in_valid && in_ready)
                parse_byte(in_data);
        end
    end

    // watchdog on cycles with no request moving on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[comma_field_record_parser_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        reset_parser();
        build_directed();
        build_random();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (tx_bytes_q.size() != 0 || in_valid)
            @(negedge clk);
        while (record_results_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("[comma_field_record_parser_unit] OK");
        else
            $display("[comma_field_record_parser_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
